### src/rec_pkg.sv
// Shared constants, types and state codes for the row edge count mode block.
`timescale 1ns / 1ps

package rec_pkg;

    localparam int CountW   = 10;
    localparam int BinW     = 11;
    localparam int HistDepth = 1024;
    localparam int AddrW    = $clog2(HistDepth);

    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};
    localparam logic [BinW-1:0]   BIN_MAX   = {BinW{1'b1}};
    localparam logic [AddrW-1:0]  ADDR_LAST = AddrW'(HistDepth - 1);

    typedef logic [CountW-1:0] count_t;
    typedef logic [BinW-1:0]   bin_t;
    typedef logic [AddrW-1:0]  addr_t;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_EMIT   = 4'b1000
    } rec_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic count_take;   // pixel accepted that is not a row end
        logic row_close;    // row-end pixel accepted: read the bin
        logic bin_update;   // write incremented bin, update mode
        logic out_load;     // move mode into result register
        logic clear_step;   // zero one histogram entry
    } rec_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_busy;     // result register full and not taken this cycle
        logic clear_last;   // clear sweep at its final entry
    } rec_status_t;

endpackage

### src/rec_if.sv
// Pixel request and result request channel interfaces.
`timescale 1ns / 1ps

interface rec_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_blue;
    logic [7:0] edge_green;
    logic [7:0] edge_red;
    logic [7:0] right_blue;
    logic [7:0] right_green;
    logic [7:0] right_red;
    logic       last_in_row;
    logic       last_in_frame;

    modport source (
        output valid, edge_blue, edge_green, edge_red,
        output right_blue, right_green, right_red, last_in_row, last_in_frame,
        input  ready
    );
    modport sink (
        input  valid, edge_blue, edge_green, edge_red,
        input  right_blue, right_green, right_red, last_in_row, last_in_frame,
        output ready
    );
endinterface

interface rec_result_if;
    logic        valid;
    logic        ready;
    logic [9:0]  mode_count;
    logic [10:0] mode_rows;

    modport source (output valid, mode_count, mode_rows, input ready);
    modport sink (input valid, mode_count, mode_rows, output ready);
endinterface

### src/row_edge_count_mode.sv
// Top level: per-row edge pixel count histogram and frame mode.
// Throughput: one pixel request per cycle while idle; after a row-end pixel, intake
// pauses for the histogram read-modify-write on the single-port-pair memory.
// Result: after the frame-end bin update, the emit state loads the result register once the previous result is taken.
// After each frame a sweep clears all 1024 histogram entries, no pixels taken.
// Reset: asynchronous, active low; the same clear sweep runs after it.
`timescale 1ns / 1ps

module row_edge_count_mode (
    input logic          clk,
    input logic          rst_n,
    rec_pixel_if.sink    pixel,
    rec_result_if.source result
);
    import rec_pkg::*;

    rec_cmd_t    cmd;
    rec_status_t status;

    rec_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pixel.valid),
        .last_in_row   (pixel.last_in_row),
        .last_in_frame (pixel.last_in_frame),
        .in_ready      (pixel.ready),
        .status        (status),
        .cmd           (cmd)
    );

    rec_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .edge_blue   (pixel.edge_blue),
        .edge_green  (pixel.edge_green),
        .edge_red    (pixel.edge_red),
        .right_blue  (pixel.right_blue),
        .right_green (pixel.right_green),
        .right_red   (pixel.right_red),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .mode_count  (result.mode_count),
        .mode_rows   (result.mode_rows)
    );

endmodule

### src/rec_ctrl.sv
// Controller state machine: pixel intake, bin update, result hand-off, clear sweep.
`timescale 1ns / 1ps

module rec_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               last_in_row,
    input  logic               last_in_frame,
    output logic               in_ready,
    input  rec_pkg::rec_status_t status,
    output rec_pkg::rec_cmd_t    cmd
);
    import rec_pkg::*;

    rec_state_t state_reg;
    rec_state_t state_next;
    logic       frame_reg;
    logic       frame_next;
    logic       take;
    logic       row_end;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;
    assign row_end  = last_in_row || last_in_frame;

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        frame_next = frame_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.count_take = take && !row_end;
                cmd.row_close  = take && row_end;
                if (take && row_end)
                begin
                    frame_next = last_in_frame;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.bin_update = 1'b1;
                state_next     = frame_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Hold state; reset starts with a clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            frame_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            frame_reg <= frame_next;
        end
    end

endmodule

### src/rec_datapath.sv
// Datapath: row counter, histogram memory, running mode and result register.
`timescale 1ns / 1ps

module rec_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rec_pkg::rec_cmd_t    cmd,
    output rec_pkg::rec_status_t status,
    input  logic [7:0]           edge_blue,
    input  logic [7:0]           edge_green,
    input  logic [7:0]           edge_red,
    input  logic [7:0]           right_blue,
    input  logic [7:0]           right_green,
    input  logic [7:0]           right_red,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [9:0]           mode_count,
    output logic [10:0]          mode_rows
);
    import rec_pkg::*;

    bin_t   hist [HistDepth];
    bin_t   rd_data_reg;
    count_t row_count_reg;
    count_t best_value_reg;
    bin_t   best_rows_reg;
    addr_t  clear_ptr_reg;
    logic   out_valid_reg;
    count_t mode_count_reg;
    bin_t   mode_rows_reg;

    logic   qualify;
    bin_t   bin_inc;
    logic   best_take;
    logic   mem_we;
    addr_t  mem_waddr;
    bin_t   mem_wdata;

    // Qualify: any edge channel set and right neighbour not black
    assign qualify = ((edge_blue | edge_green | edge_red) != 8'd0) &&
                     ((right_blue | right_green | right_red) != 8'd0);

    // Saturating bin increment and mode compare, smaller count wins ties
    assign bin_inc   = (rd_data_reg != BIN_MAX) ? rd_data_reg + 1'b1 : rd_data_reg;
    assign best_take = (bin_inc > best_rows_reg) ||
                       ((bin_inc == best_rows_reg) && (row_count_reg < best_value_reg));

    // Share the write port between bin update and clear sweep
    assign mem_we    = cmd.bin_update || cmd.clear_step;
    assign mem_waddr = cmd.clear_step ? clear_ptr_reg : addr_t'(row_count_reg);
    assign mem_wdata = cmd.clear_step ? '0 : bin_inc;

    // Histogram memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist[mem_waddr] <= mem_wdata;
        end
        if (cmd.row_close)
        begin
            rd_data_reg <= hist[addr_t'(row_count_reg)];
        end
    end

    // Count qualifying pixels that are not row ends, saturating; drop to zero once the row is binned
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
        end
        else if (cmd.bin_update)
        begin
            row_count_reg <= '0;
        end
        else if (cmd.count_take && qualify && (row_count_reg != COUNT_MAX))
        begin
            row_count_reg <= row_count_reg + 1'b1;
        end
    end

    // Track running mode; clear it when the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_value_reg <= '0;
            best_rows_reg  <= '0;
        end
        else if (cmd.out_load)
        begin
            best_value_reg <= '0;
            best_rows_reg  <= '0;
        end
        else if (cmd.bin_update && best_take)
        begin
            best_value_reg <= row_count_reg;
            best_rows_reg  <= bin_inc;
        end
    end

    // Advance clear pointer; it wraps to zero after the last entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_ptr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_ptr_reg <= clear_ptr_reg + 1'b1;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mode_count_reg <= best_value_reg;
            mode_rows_reg  <= best_rows_reg;
        end
    end

    assign status.out_busy   = out_valid_reg && !out_ready;
    assign status.clear_last = (clear_ptr_reg == ADDR_LAST);

    assign out_valid  = out_valid_reg;
    assign mode_count = mode_count_reg;
    assign mode_rows  = mode_rows_reg;

endmodule
